### design/mlp_three_two_one_sigmoid_core_macros.svh
// Assertion helpers shared by the RTL.
// Synthesis builds define SYNTHESIS and get empty bodies.
`ifndef MLP_THREE_TWO_ONE_SIGMOID_CORE_MACROS_SVH
`define MLP_THREE_TWO_ONE_SIGMOID_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define MLP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mlp321 assertion failed");

// Checked at every edge, reset included.
`define MLP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mlp321 assertion failed");

`else

`define MLP_ASSERT(label, clk, rst_n, prop)
`define MLP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### design/mlp321_pkg.sv
package mlp321_pkg;

    localparam int SIG_DEPTH_DEF = 256;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H1_WEIGHTS  = 3'd0,
        CFG_H1_BIAS     = 3'd1,
        CFG_H2_WEIGHTS  = 3'd2,
        CFG_H2_BIAS     = 3'd3,
        CFG_OUT_WEIGHTS = 3'd4,
        CFG_OUT_BIAS    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] feature_two;
        logic signed [15:0] feature_one;
        logic signed [15:0] feature_zero;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] network_output;
        logic [15:0] hidden_two_activation;
        logic [15:0] hidden_one_activation;
    } t_out_beat;

    // Clamp a widened Q4.12 sum into 16 bits.
    function automatic logic signed [15:0] sat_q412(input logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Shift-subtract divide, used only while building the sigmoid table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid table entry k of depth entries over [-8,8), unsigned Q0.16.
    function automatic logic [15:0] sig_entry(input int unsigned k, input int unsigned depth);
        longint      num;
        logic        nonneg;
        logic [63:0] mag;
        logic [63:0] a;
        logic [63:0] g;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] den;
        logic [63:0] q;
        longint      sum;
        num    = 16 * longint'(k) - 8 * longint'(depth);
        nonneg = (num >= 0);
        mag    = nonneg ? 64'(num) : 64'(-num);
        a      = udiv64(mag << 31, 64'(depth));
        g      = a >> 4;
        term   = 64'd1 << 31;
        sum    = longint'(1) << 31;
        for (int i = 1; i <= 16; i++) begin
            term = udiv64((term * g) >> 31, 64'(i));
            if (i[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        r = (sum < 0) ? 64'd0 : 64'(sum);
        for (int i = 0; i < 4; i++) begin
            r = (r * r) >> 31;
        end
        den = (64'd1 << 31) + r;
        if (nonneg) begin
            q = udiv64((64'd1 << 47) + (den >> 1), den);
        end else begin
            q = udiv64((r << 16) + (den >> 1), den);
        end
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

endpackage

### design/mlp_three_two_one_sigmoid_core.sv
// 3-2-1 sigmoid network, one result beat per feature beat.
// Throughput: one beat per cycle; each stage stalls only when full and blocked.
// Sigmoid table: constant ROM, read with registered data, three read sites.
// Reset (synchronous, active low): empties the pipeline, clears all weights and biases.
`include "mlp_three_two_one_sigmoid_core_macros.svh"

module mlp_three_two_one_sigmoid_core
    import mlp321_pkg::*;
#(
    parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // feature beats
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data
);

    localparam int IW   = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int PW   = 16 + $clog2(SIGMOID_TABLE_DEPTH + 1);
    localparam int NSTG = 8;

    // Map a saturated Q4.12 sum onto a table row: ((s + 32768) * depth) >> 16.
    function automatic logic [IW-1:0] tab_idx(input logic signed [15:0] s);
        logic [PW-1:0] prod;
        prod = PW'({~s[15], s[14:0]}) * PW'(SIGMOID_TABLE_DEPTH);
        return prod[16 +: IW];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the pipe
    // is idle; the block does not enforce this. Every stage reads them directly.
    // ------------------------------------------------------------------
    logic [47:0]        r_h1_w;
    logic signed [15:0] r_h1_b;
    logic [47:0]        r_h2_w;
    logic signed [15:0] r_h2_b;
    logic [31:0]        r_out_w;
    logic signed [15:0] r_out_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_w  <= '0;
            r_h1_b  <= '0;
            r_h2_w  <= '0;
            r_h2_b  <= '0;
            r_out_w <= '0;
            r_out_b <= '0;
        end else if (i_cfg_valid) begin
            // unlisted indexes drop the beat
            unique case (i_cfg_index)
                CFG_H1_WEIGHTS:  r_h1_w  <= i_cfg_data[47:0];
                CFG_H1_BIAS:     r_h1_b  <= i_cfg_data[15:0];
                CFG_H2_WEIGHTS:  r_h2_w  <= i_cfg_data[47:0];
                CFG_H2_BIAS:     r_h2_b  <= i_cfg_data[15:0];
                CFG_OUT_WEIGHTS: r_out_w <= i_cfg_data[31:0];
                CFG_OUT_BIAS:    r_out_b <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sigmoid ROM. Two copies of the same constants: the hidden stage
    // reads two rows per cycle, the output stage one.
    // ------------------------------------------------------------------
    logic [15:0] w_rom_hid [SIGMOID_TABLE_DEPTH];
    logic [15:0] w_rom_out [SIGMOID_TABLE_DEPTH];

    for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [15:0] ENT = sig_entry(k, SIGMOID_TABLE_DEPTH);
        assign w_rom_hid[k] = ENT;
        assign w_rom_out[k] = ENT;
    end

    // ------------------------------------------------------------------
    // Pipeline control. Stage k loads when empty or when its content
    // moves on; a bubble anywhere lets input keep flowing under a stall.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_ld;

    always_comb begin
        w_ld[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_ld[0];
    assign o_out_valid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 0: six hidden products, Q8.24.
    // ------------------------------------------------------------------
    logic signed [31:0] r_hp1 [3];
    logic signed [31:0] r_hp2 [3];

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_hp1[0] <= i_in_data.feature_zero * $signed(r_h1_w[15:0]);
            r_hp1[1] <= i_in_data.feature_one  * $signed(r_h1_w[31:16]);
            r_hp1[2] <= i_in_data.feature_two  * $signed(r_h1_w[47:32]);
            r_hp2[0] <= i_in_data.feature_zero * $signed(r_h2_w[15:0]);
            r_hp2[1] <= i_in_data.feature_one  * $signed(r_h2_w[31:16]);
            r_hp2[2] <= i_in_data.feature_two  * $signed(r_h2_w[47:32]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: add bias, floor back to Q4.12, saturate.
    // ------------------------------------------------------------------
    logic signed [34:0] w_hacc1;
    logic signed [34:0] w_hacc2;
    logic signed [15:0] r_hs1;
    logic signed [15:0] r_hs2;

    assign w_hacc1 = 35'(r_hp1[0]) + 35'(r_hp1[1]) + 35'(r_hp1[2]) + (35'(r_h1_b) <<< 12);
    assign w_hacc2 = 35'(r_hp2[0]) + 35'(r_hp2[1]) + 35'(r_hp2[2]) + (35'(r_h2_b) <<< 12);

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            // dropping the low 12 bits of a two's-complement sum is a floor
            r_hs1 <= sat_q412(24'($signed(w_hacc1[34:12])));
            r_hs2 <= sat_q412(24'($signed(w_hacc2[34:12])));
        end
    end

    // Stage 2: table rows for both hidden neurons.
    logic [IW-1:0] r_hi1;
    logic [IW-1:0] r_hi2;

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            r_hi1 <= tab_idx(r_hs1);
            r_hi2 <= tab_idx(r_hs2);
        end
    end

    // Stage 3: ROM read gives the hidden activations.
    logic [1:0][15:0] r_ha;

    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r_ha[0] <= w_rom_hid[r_hi1];
            r_ha[1] <= w_rom_hid[r_hi2];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: output products, unsigned Q0.16 times signed Q4.12.
    // Hidden activations ride along to the result beat.
    // ------------------------------------------------------------------
    logic signed [32:0] r_op [2];
    logic [1:0][15:0]   r_hc4;

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r_op[0] <= $signed({1'b0, r_ha[0]}) * $signed(r_out_w[15:0]);
            r_op[1] <= $signed({1'b0, r_ha[1]}) * $signed(r_out_w[31:16]);
            r_hc4   <= r_ha;
        end
    end

    // Stage 5: add bias, floor by 16 bits, saturate.
    logic signed [34:0] w_oacc;
    logic signed [15:0] r_os;
    logic [1:0][15:0]   r_hc5;

    assign w_oacc = 35'(r_op[0]) + 35'(r_op[1]) + (35'(r_out_b) <<< 16);

    always_ff @(posedge i_clk) begin
        if (w_ld[5]) begin
            r_os  <= sat_q412(24'($signed(w_oacc[34:16])));
            r_hc5 <= r_hc4;
        end
    end

    // Stage 6: output table row.
    logic [IW-1:0]    r_oi;
    logic [1:0][15:0] r_hc6;

    always_ff @(posedge i_clk) begin
        if (w_ld[6]) begin
            r_oi  <= tab_idx(r_os);
            r_hc6 <= r_hc5;
        end
    end

    // Stage 7: ROM read into the output register.
    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (w_ld[7]) begin
            r_out.network_output        <= w_rom_out[r_oi];
            r_out.hidden_one_activation <= r_hc6[0];
            r_out.hidden_two_activation <= r_hc6[1];
        end
    end

    assign o_out_data = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MLP_ASSERT_ALWAYS(a_rst_empties, i_clk, !i_rst_n |=> !o_out_valid)
    `MLP_ASSERT(a_full_blocks, i_clk, i_rst_n, (&r_vld) && !i_out_ready |-> !o_in_ready)
    `MLP_ASSERT(a_full_flows, i_clk, i_rst_n, (&r_vld) && i_out_ready |-> o_in_ready)
    `MLP_ASSERT(a_stall_holds, i_clk, i_rst_n, r_vld[3] && !w_ld[3] |=> r_vld[3] && $stable(r_ha))

endmodule
